[rtl/gait_terrain_classifier_assert.svh]
// Assertion macros for the gait terrain classifier checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GAIT_TERRAIN_CLASSIFIER_ASSERT_SVH
`define GAIT_TERRAIN_CLASSIFIER_ASSERT_SVH

// check outside reset
`define GTC_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check through reset as well
`define GTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gtc_pkg.sv]
// Shared types, codes and constants of the gait terrain classifier.
// No dependencies; imported by every module of the block.
package gtc_pkg;

  localparam int COUNT_BITS_DEF        = 32;
  localparam int SWING_LIMIT_DEF       = 1000;
  localparam int STANCE_LIMIT_DEF      = 3000;
  localparam int STAIR_DOWN_WINDOW_DEF = 600;

  localparam logic [2:0] TERRAIN_FLAT   = 3'd0;
  localparam logic [2:0] TERRAIN_URAMP  = 3'd1;
  localparam logic [2:0] TERRAIN_USTAIR = 3'd2;
  localparam logic [2:0] TERRAIN_DRAMP  = 3'd3;
  localparam logic [2:0] TERRAIN_DSTAIR = 3'd4;

  localparam logic [1:0] EVENT_STRIKE = 2'd1;
  localparam logic [1:0] EVENT_OFF    = 2'd2;

  localparam logic [1:0] SLOPE_NONE = 2'd0;
  localparam logic [1:0] SLOPE_UP   = 2'd1;
  localparam logic [1:0] SLOPE_DOWN = 2'd2;

  localparam logic [2:0] CFG_STAIR_UP_Y   = 3'd0;
  localparam logic [2:0] CFG_STAIR_UP_Z   = 3'd1;
  localparam logic [2:0] CFG_STAIR_DOWN_Y = 3'd2;
  localparam logic [2:0] CFG_STAIR_DOWN_Z = 3'd3;
  localparam logic [2:0] CFG_RAMP_UP_Y    = 3'd4;
  localparam logic [2:0] CFG_RAMP_UP_Z    = 3'd5;
  localparam logic [2:0] CFG_RAMP_DOWN_Z  = 3'd6;
  localparam logic [2:0] CFG_SLOPE_BIN    = 3'd7;

  localparam logic signed [15:0] RST_STAIR_UP_Y   = 16'sd819;
  localparam logic signed [15:0] RST_STAIR_UP_Z   = 16'sd819;
  localparam logic signed [15:0] RST_STAIR_DOWN_Y = 16'sd1843;
  localparam logic signed [15:0] RST_STAIR_DOWN_Z = -16'sd328;
  localparam logic signed [15:0] RST_RAMP_UP_Y    = 16'sd2662;
  localparam logic signed [15:0] RST_RAMP_UP_Z    = 16'sd532;
  localparam logic signed [15:0] RST_RAMP_DOWN_Z  = -16'sd205;
  localparam logic [14:0]        RST_SLOPE_BIN    = 15'd410;

  localparam logic signed [15:0] BACKWARD_Y  = -16'sd122;
  localparam logic signed [15:0] VERTICAL_Z  = 16'sd20;
  localparam logic [14:0]        TRAVEL_MAX  = 15'd6963;
  localparam logic signed [15:0] UP_END_Z    = -16'sd205;
  localparam logic signed [15:0] DOWN_END_Z  = 16'sd205;
  localparam logic signed [15:0] TORQUE_LIM  = 16'sd1920;
  localparam logic signed [15:0] ROLL_LIM    = -16'sd2048;
  localparam logic signed [15:0] S16_MIN     = -16'sd32768;
  localparam logic signed [15:0] S16_MAX     = 16'sd32767;

  typedef struct packed {
    logic               swinging;
    logic [1:0]         gait_event;
    logic [31:0]        sample_count;
    logic [31:0]        foot_off_count;
    logic [31:0]        foot_still_count;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        travel;
    logic signed [15:0] joint_torque;
    logic signed [15:0] roll_rate;
    logic signed [15:0] slope_estimate;
    logic signed [15:0] stride_end_z;
  } gtc_in_t;

  typedef struct packed {
    logic [2:0] terrain;
    logic       decided;
    logic       armed;
    logic [1:0] slope_verdict;
  } gtc_out_t;

  typedef struct packed {
    logic signed [15:0] stair_up_y_limit;
    logic signed [15:0] stair_up_z_limit;
    logic signed [15:0] stair_down_y_limit;
    logic signed [15:0] stair_down_z_limit;
    logic signed [15:0] ramp_up_y_limit;
    logic signed [15:0] ramp_up_z_limit;
    logic signed [15:0] ramp_down_z_limit;
    logic [14:0]        slope_bin_width;
  } gtc_cfg_t;

endpackage

[rtl/gait_terrain_classifier.sv]
// Gait terrain classifier, top level: input register, classifier core,
// configuration registers and result register. Depends on gtc_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one gait sample per
//   control tick; an item is taken at a clock edge with in_valid high and
//   in_stall low. Each item yields exactly one result on out_valid/
//   out_stall/out_data (terrain, decided, armed, slope_verdict).
//   The result passes through the input register and the result register,
//   around one pass of compare logic in gtc_core; one item per cycle is
//   sustained while out_stall is low.
//   While out_stall holds a result, the input register still takes one more
//   item; in_stall rises only when both registers are full.
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_wdata;
//   cfg_ready is always high. Write only while no item is in flight.
//   Synchronous reset (rst_n low) empties both registers, restores the
//   register defaults and clears all tracking state to zero and flat.
module gait_terrain_classifier #(
  parameter int COUNT_BITS        = gtc_pkg::COUNT_BITS_DEF,
  parameter int SWING_LIMIT       = gtc_pkg::SWING_LIMIT_DEF,
  parameter int STANCE_LIMIT      = gtc_pkg::STANCE_LIMIT_DEF,
  parameter int STAIR_DOWN_WINDOW = gtc_pkg::STAIR_DOWN_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gtc_pkg::gtc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gtc_pkg::gtc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import gtc_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  gtc_in_t  s1_data_r;
  logic     out_valid_r, out_valid_nxt;
  gtc_out_t out_data_r;
  gtc_out_t result;
  gtc_cfg_t cfg;
  logic     out_free, fire, take;

  assign out_free = ~out_valid_r | ~out_stall;
  assign fire     = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;
  assign take     = in_valid & ~in_stall;

  assign s1_valid_nxt  = take | (s1_valid_r & ~fire);
  assign out_valid_nxt = fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  gtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gtc_core #(
    .COUNT_BITS        (COUNT_BITS),
    .SWING_LIMIT       (SWING_LIMIT),
    .STANCE_LIMIT      (STANCE_LIMIT),
    .STAIR_DOWN_WINDOW (STAIR_DOWN_WINDOW)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/gtc_cfg_regs.sv]
// Configuration register file of the gait terrain classifier.
// Depends on gtc_pkg for the register indexes, reset values and gtc_cfg_t.
module gtc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output gtc_pkg::gtc_cfg_t cfg
);
  import gtc_pkg::*;

  gtc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stair_up_y_limit   <= RST_STAIR_UP_Y;
      cfg_r.stair_up_z_limit   <= RST_STAIR_UP_Z;
      cfg_r.stair_down_y_limit <= RST_STAIR_DOWN_Y;
      cfg_r.stair_down_z_limit <= RST_STAIR_DOWN_Z;
      cfg_r.ramp_up_y_limit    <= RST_RAMP_UP_Y;
      cfg_r.ramp_up_z_limit    <= RST_RAMP_UP_Z;
      cfg_r.ramp_down_z_limit  <= RST_RAMP_DOWN_Z;
      cfg_r.slope_bin_width    <= RST_SLOPE_BIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STAIR_UP_Y:   cfg_r.stair_up_y_limit   <= $signed(cfg_wdata);
        CFG_STAIR_UP_Z:   cfg_r.stair_up_z_limit   <= $signed(cfg_wdata);
        CFG_STAIR_DOWN_Y: cfg_r.stair_down_y_limit <= $signed(cfg_wdata);
        CFG_STAIR_DOWN_Z: cfg_r.stair_down_z_limit <= $signed(cfg_wdata);
        CFG_RAMP_UP_Y:    cfg_r.ramp_up_y_limit    <= $signed(cfg_wdata);
        CFG_RAMP_UP_Z:    cfg_r.ramp_up_z_limit    <= $signed(cfg_wdata);
        CFG_RAMP_DOWN_Z:  cfg_r.ramp_down_z_limit  <= $signed(cfg_wdata);
        CFG_SLOPE_BIN:    cfg_r.slope_bin_width    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/gtc_core.sv]
// Classifier state and next-state logic: stance tracking, foot-off slope
// verdict and swing terrain rules. Depends on gtc_pkg.
module gtc_core #(
  parameter int COUNT_BITS        = gtc_pkg::COUNT_BITS_DEF,
  parameter int SWING_LIMIT       = gtc_pkg::SWING_LIMIT_DEF,
  parameter int STANCE_LIMIT      = gtc_pkg::STANCE_LIMIT_DEF,
  parameter int STAIR_DOWN_WINDOW = gtc_pkg::STAIR_DOWN_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  gtc_pkg::gtc_in_t  item,
  input  gtc_pkg::gtc_cfg_t cfg,
  output gtc_pkg::gtc_out_t result
);
  import gtc_pkg::*;

  localparam int CW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  logic               backward_r, backward_nxt;
  logic               vertical_r, vertical_nxt;
  logic               decided_r, decided_nxt;
  logic               armed_c;
  logic [1:0]         slope_r, slope_nxt;
  logic [2:0]         terrain_r, terrain_nxt;
  logic signed [15:0] tq_peak_r, tq_peak_nxt;
  logic signed [15:0] tq_trough_r, tq_trough_nxt;
  logic signed [15:0] roll_trough_r, roll_trough_nxt;

  logic [CW-1:0]      now_c, off_c, still_c, since_off;
  logic               long_swing, in_window, early_stance;
  logic signed [15:0] bin_pos, bin_neg;
  logic               hit, stop;

  assign now_c        = item.sample_count[CW-1:0];
  assign off_c        = item.foot_off_count[CW-1:0];
  assign still_c      = item.foot_still_count[CW-1:0];
  assign since_off    = now_c - off_c;
  assign long_swing   = 64'(since_off) > 64'(SWING_LIMIT);
  assign in_window    = 64'(since_off) < 64'(STAIR_DOWN_WINDOW);
  assign early_stance = 64'(now_c) < 64'(STANCE_LIMIT);
  assign bin_pos      = $signed({1'b0, cfg.slope_bin_width});
  assign bin_neg      = -bin_pos;

  always_comb begin
    backward_nxt    = backward_r | (item.pos_y < BACKWARD_Y);
    vertical_nxt    = vertical_r | (item.pos_z > VERTICAL_Z);
    decided_nxt     = decided_r;
    armed_c         = item.swinging & ~backward_nxt & vertical_nxt & ~decided_r;
    slope_nxt       = slope_r;
    terrain_nxt     = terrain_r;
    tq_peak_nxt     = tq_peak_r;
    tq_trough_nxt   = tq_trough_r;
    roll_trough_nxt = roll_trough_r;
    hit             = 1'b0;
    stop            = 1'b0;

    if (armed_c) begin
      hit = 1'b1;
      if (item.travel > TRAVEL_MAX || long_swing) begin
        decided_nxt = 1'b1;
      end else if (item.pos_y < cfg.stair_up_y_limit && item.pos_z > cfg.stair_up_z_limit) begin
        terrain_nxt = TERRAIN_USTAIR;
        decided_nxt = 1'b1;
      end else if (!(item.pos_y < cfg.stair_up_y_limit) && slope_r == SLOPE_UP) begin
        terrain_nxt = TERRAIN_URAMP;
        decided_nxt = 1'b1;
      end else if (item.pos_y < cfg.stair_down_y_limit &&
                   item.pos_z < cfg.stair_down_z_limit && in_window) begin
        terrain_nxt = TERRAIN_DSTAIR;
        decided_nxt = 1'b1;
      end else if (!(item.pos_y < cfg.stair_down_y_limit) && slope_r == SLOPE_DOWN) begin
        terrain_nxt = TERRAIN_DRAMP;
        decided_nxt = 1'b1;
      end else if (item.pos_y > cfg.ramp_up_y_limit) begin
        decided_nxt = 1'b1;
        if (roll_trough_r < ROLL_LIM && item.pos_z > cfg.ramp_up_z_limit) begin
          terrain_nxt = TERRAIN_URAMP;
        end else if (roll_trough_r < ROLL_LIM && item.pos_z < cfg.ramp_down_z_limit) begin
          terrain_nxt = TERRAIN_DRAMP;
        end else begin
          terrain_nxt = TERRAIN_FLAT;
        end
      end else begin
        hit = 1'b0;
      end
    end

    if (!hit) begin
      if (now_c == still_c) begin
        vertical_nxt = 1'b0;
        backward_nxt = 1'b0;
      end
      if (item.gait_event == EVENT_STRIKE) begin
        tq_peak_nxt     = S16_MIN;
        tq_trough_nxt   = S16_MAX;
        roll_trough_nxt = S16_MAX;
        armed_c         = 1'b0;
      end
      if (item.gait_event == EVENT_OFF) begin
        slope_nxt   = SLOPE_NONE;
        terrain_nxt = TERRAIN_FLAT;
        if (early_stance && (tq_peak_r > TORQUE_LIM || tq_trough_r < -TORQUE_LIM) &&
            still_c != '0) begin
          decided_nxt = 1'b0;
          if (item.slope_estimate < bin_neg && item.stride_end_z > UP_END_Z &&
              roll_trough_r < ROLL_LIM) begin
            slope_nxt = SLOPE_UP;
          end
          if (item.slope_estimate > bin_pos && item.stride_end_z < DOWN_END_Z &&
              roll_trough_r < ROLL_LIM) begin
            slope_nxt = SLOPE_DOWN;
          end
        end else begin
          stop = 1'b1;
        end
      end
      if (!stop && !item.swinging) begin
        if (item.joint_torque > tq_peak_nxt) begin
          tq_peak_nxt = item.joint_torque;
        end
        if (item.joint_torque < tq_trough_nxt) begin
          tq_trough_nxt = item.joint_torque;
        end
        if (item.roll_rate < roll_trough_nxt) begin
          roll_trough_nxt = item.roll_rate;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backward_r    <= 1'b0;
      vertical_r    <= 1'b0;
      decided_r     <= 1'b0;
      slope_r       <= SLOPE_NONE;
      terrain_r     <= TERRAIN_FLAT;
      tq_peak_r     <= '0;
      tq_trough_r   <= '0;
      roll_trough_r <= '0;
    end else if (step) begin
      backward_r    <= backward_nxt;
      vertical_r    <= vertical_nxt;
      decided_r     <= decided_nxt;
      slope_r       <= slope_nxt;
      terrain_r     <= terrain_nxt;
      tq_peak_r     <= tq_peak_nxt;
      tq_trough_r   <= tq_trough_nxt;
      roll_trough_r <= roll_trough_nxt;
    end
  end

  assign result.terrain       = terrain_nxt;
  assign result.decided       = decided_nxt;
  assign result.armed         = armed_c;
  assign result.slope_verdict = slope_nxt;

endmodule

[rtl/gtc_checker.sv]
// Port-level checker for the gait terrain classifier, bound to the top level.
// Depends on gtc_pkg and gait_terrain_classifier_assert.svh.
`include "gait_terrain_classifier_assert.svh"

module gtc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input gtc_pkg::gtc_out_t out_data
);
  import gtc_pkg::*;

  `GTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "result after reset")
  `GTC_ASSERT_ON(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "item dropped")
  `GTC_ASSERT_ON(a_terrain_code, out_valid |-> out_data.terrain <= TERRAIN_DSTAIR, "bad terrain")
  `GTC_ASSERT_ON(a_slope_code, out_valid |-> out_data.slope_verdict != 2'd3, "bad slope")
  `GTC_ASSERT_ON(a_terrain_decided, out_valid && out_data.terrain != TERRAIN_FLAT |-> out_data.decided, "undecided")

endmodule

bind gait_terrain_classifier gtc_checker u_gtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
